// File: rtl/maze_wall_map_store_defines.svh
// ----------------------------------------------------------------------------
// maze wall map store assertion macros
// clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MAZE_WALL_MAP_STORE_DEFINES_SVH
`define MAZE_WALL_MAP_STORE_DEFINES_SVH

// same-cycle implication
`define MWMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MWMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mwms_pkg.sv
// ----------------------------------------------------------------------------
// mwms_pkg
// shared constants, types and helpers of the maze wall map store
// ----------------------------------------------------------------------------
package mwms_pkg;

    localparam int MAZE_SIDE  = 16;
    localparam int COORD_W    = 4;
    localparam int BANK_DEPTH = MAZE_SIDE / 2 + 1;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int WORD_W     = 2 * MAZE_SIDE;
    localparam int NUM_BANKS  = 4;
    localparam int Q_DEPTH    = 4;
    localparam int QAW        = $clog2(Q_DEPTH);
    localparam int QCW        = $clog2(Q_DEPTH + 1);

    // bank indexes: rows split by parity
    localparam int BK_HE = 0;
    localparam int BK_HO = 1;
    localparam int BK_VE = 2;
    localparam int BK_VO = 3;

    localparam logic [1:0] ACT_ADD_REL  = 2'd0;
    localparam logic [1:0] ACT_ADD_ABS  = 2'd1;
    localparam logic [1:0] ACT_QRY_WALL = 2'd2;
    localparam logic [1:0] ACT_QRY_EXPL = 2'd3;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_W = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_E = 2'd3;

    typedef logic [MAZE_SIDE-1:0] row_t;
    typedef logic [COORD_W:0]     rowidx_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [2:0]         heading;
        logic               seen_left;
        logic               seen_right;
        logic               seen_front;
        logic               wall_north;
        logic               wall_west;
        logic               wall_south;
        logic               wall_east;
    } item_t;

    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [WORD_W-1:0]  data;
    } wr_t;

    typedef struct packed {
        logic wall_present;
        logic cell_explored;
    } res_t;

    // of rows c and c+1, the one with the given parity
    function automatic rowidx_t bank_row(input logic [COORD_W-1:0] c, input logic odd);
        rowidx_t r;
        r = {1'b0, c};
        if (c[0] != odd)
        begin
            r = r + rowidx_t'(1);
        end
        return r;
    endfunction

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [COORD_W-1:0] c,
                                                     input logic odd);
        rowidx_t r;
        r = bank_row(c, odd);
        return BANK_AW'(r >> 1);
    endfunction

    // word = {walls, known}
    function automatic logic [WORD_W-1:0] reset_word(input logic vert, input rowidx_t row);
        row_t r;
        r = '0;
        if (row == '0 || int'(row) == MAZE_SIDE)
        begin
            r = '1;
        end
        else if (vert && row == rowidx_t'(1))
        begin
            r = row_t'(1);
        end
        return {r, r};
    endfunction

endpackage

// File: rtl/mwms_ram.sv
// ----------------------------------------------------------------------------
// mwms_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mwms_ram #(
    parameter int DEPTH = 9,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mwms_bank.sv
// ----------------------------------------------------------------------------
// mwms_bank
// one parity bank of wall rows: ram, written flags and write forwarding
// ----------------------------------------------------------------------------
`include "maze_wall_map_store_defines.svh"

module mwms_bank (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [mwms_pkg::BANK_AW-1:0] rd_addr,
    input  mwms_pkg::wr_t                wr,
    input  logic [mwms_pkg::WORD_W-1:0]  dflt,
    output logic [mwms_pkg::WORD_W-1:0]  rd_data
);
    import mwms_pkg::*;

    logic [BANK_DEPTH-1:0] valid_reg;
    logic [BANK_DEPTH-1:0] valid_next;
    wr_t                   last_wr_reg;
    logic [BANK_AW-1:0]    rd_addr_reg;
    logic                  rd_valid_reg;
    logic [WORD_W-1:0]     ram_q;

    mwms_ram #(
        .DEPTH (BANK_DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next = valid_reg | (BANK_DEPTH'(1) << wr.addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            last_wr_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            last_wr_reg <= wr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_addr_reg  <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // write in the read cycle wins, unwritten rows read as their reset value
    always_comb
    begin
        if (last_wr_reg.en && last_wr_reg.addr == rd_addr_reg)
        begin
            rd_data = last_wr_reg.data;
        end
        else if (rd_valid_reg)
        begin
            rd_data = ram_q;
        end
        else
        begin
            rd_data = dflt;
        end
    end

    `MWMS_ASSERT_NEXT(a_bank_fwd, wr.en && rd_en && rd_addr == wr.addr,
                      rd_data == $past(wr.data), "bank read missed same-edge write")

endmodule

// File: rtl/mwms_update.sv
// ----------------------------------------------------------------------------
// mwms_update
// read-modify-write step: sets wall and known bits, answers queries
// ----------------------------------------------------------------------------
module mwms_update (
    input  logic                        s1_valid,
    input  mwms_pkg::item_t             item,
    input  logic [mwms_pkg::WORD_W-1:0] rd_word [mwms_pkg::NUM_BANKS],
    output logic [mwms_pkg::WORD_W-1:0] dflt [mwms_pkg::NUM_BANKS],
    output mwms_pkg::wr_t               wr [mwms_pkg::NUM_BANKS],
    output mwms_pkg::res_t              res
);
    import mwms_pkg::*;

    function automatic logic [WORD_W-1:0] put_bit(input logic [WORD_W-1:0] w,
                                                  input logic [COORD_W-1:0] pos,
                                                  input logic v);
        row_t m;
        row_t walls;
        row_t known;
        m     = row_t'(1) << pos;
        known = w[MAZE_SIDE-1:0] | m;
        walls = v ? (w[WORD_W-1:MAZE_SIDE] | m) : (w[WORD_W-1:MAZE_SIDE] & ~m);
        return {walls, known};
    endfunction

    function automatic logic bit_at(input row_t r, input logic [COORD_W-1:0] pos);
        row_t s;
        s = r >> pos;
        return s[0];
    endfunction

    logic              in_maze;
    logic              rel_ok;
    logic              abs_ok;
    logic [1:0]        hd;
    logic [3:0]        dir_en;
    logic [3:0]        dir_val;
    logic [3:0]        abs_val;
    logic [WORD_W-1:0] h_lo;
    logic [WORD_W-1:0] h_hi;
    logic [WORD_W-1:0] v_lo;
    logic [WORD_W-1:0] v_hi;
    logic [WORD_W-1:0] h_lo_new;
    logic [WORD_W-1:0] h_hi_new;
    logic [WORD_W-1:0] v_lo_new;
    logic [WORD_W-1:0] v_hi_new;
    logic              q_bit;
    logic              all_known;

    always_comb
    begin
        in_maze = (int'(item.cell_x) < MAZE_SIDE) && (int'(item.cell_y) < MAZE_SIDE);
        hd      = item.heading[1:0];
        rel_ok  = s1_valid && in_maze && item.action == ACT_ADD_REL && !item.heading[2];
        abs_ok  = s1_valid && in_maze && item.action == ACT_ADD_ABS;

        abs_val[DIR_N] = item.wall_north;
        abs_val[DIR_W] = item.wall_west;
        abs_val[DIR_S] = item.wall_south;
        abs_val[DIR_E] = item.wall_east;

        // front = heading, left = heading + 1, right = heading + 3
        for (int d = 0; d < 4; d++)
        begin
            dir_en[d] = abs_ok || (rel_ok && 2'(d) != hd + 2'd2);
            if (abs_ok)
            begin
                dir_val[d] = abs_val[d];
            end
            else if (2'(d) == hd)
            begin
                dir_val[d] = item.seen_front;
            end
            else if (2'(d) == hd + 2'd1)
            begin
                dir_val[d] = item.seen_left;
            end
            else
            begin
                dir_val[d] = item.seen_right;
            end
        end

        h_lo = item.cell_y[0] ? rd_word[BK_HO] : rd_word[BK_HE];
        h_hi = item.cell_y[0] ? rd_word[BK_HE] : rd_word[BK_HO];
        v_lo = item.cell_x[0] ? rd_word[BK_VO] : rd_word[BK_VE];
        v_hi = item.cell_x[0] ? rd_word[BK_VE] : rd_word[BK_VO];

        h_lo_new = dir_en[DIR_S] ? put_bit(h_lo, item.cell_x, dir_val[DIR_S]) : h_lo;
        h_hi_new = dir_en[DIR_N] ? put_bit(h_hi, item.cell_x, dir_val[DIR_N]) : h_hi;
        v_lo_new = dir_en[DIR_W] ? put_bit(v_lo, item.cell_y, dir_val[DIR_W]) : v_lo;
        v_hi_new = dir_en[DIR_E] ? put_bit(v_hi, item.cell_y, dir_val[DIR_E]) : v_hi;

        wr[BK_HE].en   = rel_ok || abs_ok;
        wr[BK_HE].addr = bank_addr(item.cell_y, 1'b0);
        wr[BK_HE].data = item.cell_y[0] ? h_hi_new : h_lo_new;
        wr[BK_HO].en   = rel_ok || abs_ok;
        wr[BK_HO].addr = bank_addr(item.cell_y, 1'b1);
        wr[BK_HO].data = item.cell_y[0] ? h_lo_new : h_hi_new;
        wr[BK_VE].en   = rel_ok || abs_ok;
        wr[BK_VE].addr = bank_addr(item.cell_x, 1'b0);
        wr[BK_VE].data = item.cell_x[0] ? v_hi_new : v_lo_new;
        wr[BK_VO].en   = rel_ok || abs_ok;
        wr[BK_VO].addr = bank_addr(item.cell_x, 1'b1);
        wr[BK_VO].data = item.cell_x[0] ? v_lo_new : v_hi_new;

        dflt[BK_HE] = reset_word(1'b0, bank_row(item.cell_y, 1'b0));
        dflt[BK_HO] = reset_word(1'b0, bank_row(item.cell_y, 1'b1));
        dflt[BK_VE] = reset_word(1'b1, bank_row(item.cell_x, 1'b0));
        dflt[BK_VO] = reset_word(1'b1, bank_row(item.cell_x, 1'b1));

        unique case (hd)
            DIR_N:   q_bit = bit_at(h_hi[WORD_W-1:MAZE_SIDE], item.cell_x);
            DIR_W:   q_bit = bit_at(v_lo[WORD_W-1:MAZE_SIDE], item.cell_y);
            DIR_S:   q_bit = bit_at(h_lo[WORD_W-1:MAZE_SIDE], item.cell_x);
            DIR_E:   q_bit = bit_at(v_hi[WORD_W-1:MAZE_SIDE], item.cell_y);
            default: q_bit = 1'b0;
        endcase

        all_known = bit_at(h_hi[MAZE_SIDE-1:0], item.cell_x)
                 && bit_at(h_lo[MAZE_SIDE-1:0], item.cell_x)
                 && bit_at(v_lo[MAZE_SIDE-1:0], item.cell_y)
                 && bit_at(v_hi[MAZE_SIDE-1:0], item.cell_y);

        res.wall_present  = in_maze && item.action == ACT_QRY_WALL && q_bit;
        res.cell_explored = in_maze && item.action == ACT_QRY_EXPL && all_known;
    end

endmodule

// File: rtl/mwms_out_q.sv
// ----------------------------------------------------------------------------
// mwms_out_q
// small result queue between the write-back step and the output channel
// ----------------------------------------------------------------------------
`include "maze_wall_map_store_defines.svh"

module mwms_out_q (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mwms_pkg::res_t           push_res,
    output logic                     out_valid,
    input  logic                     out_stall,
    output mwms_pkg::res_t           head,
    output logic [mwms_pkg::QCW-1:0] count
);
    import mwms_pkg::*;

    res_t           q_reg [Q_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;
    logic           pop;

    assign out_valid  = count_reg != '0;
    assign pop        = out_valid && !out_stall;
    assign count_next = count_reg + QCW'(push) - QCW'(pop);
    assign head       = q_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_res;
        end
    end

    `MWMS_ASSERT_NOW(a_q_no_overflow, push && int'(count_reg) == Q_DEPTH, pop,
                     "result queue overflow")
    `MWMS_ASSERT_NOW(a_q_ptr_count, 1'b1,
                     QAW'(wr_ptr_reg - rd_ptr_reg) == count_reg[QAW-1:0],
                     "result queue pointers disagree with count")

endmodule

// File: rtl/maze_wall_map_store.sv
// ----------------------------------------------------------------------------
// maze_wall_map_store
// wall and known-wall map of a 16x16 maze, updated and queried per item
//
// channel  handshake             payload
// in       in_valid / in_stall   action cell_x cell_y heading seen_* wall_*
// out      out_valid / out_stall wall_present cell_explored
//
// an item reads its rows from four parity banks in the accept cycle and
// writes them back in the following cycle, pushing its result to the queue
// one item per cycle sustained while in_stall is low; the write-back bank port
// forwards to a read of the same row on the next item
// in_stall rises when the result queue plus the item in flight fill 4 slots
// no clearing pass after reset: per-row written flags supply reset rows
// ----------------------------------------------------------------------------
`include "maze_wall_map_store_defines.svh"

module maze_wall_map_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic [mwms_pkg::COORD_W-1:0] cell_x,
    input  logic [mwms_pkg::COORD_W-1:0] cell_y,
    input  logic [2:0]                   heading,
    input  logic                         seen_left,
    input  logic                         seen_right,
    input  logic                         seen_front,
    input  logic                         wall_north,
    input  logic                         wall_west,
    input  logic                         wall_south,
    input  logic                         wall_east,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         wall_present,
    output logic                         cell_explored
);
    import mwms_pkg::*;

    item_t              item_in;
    item_t              s1_item_reg;
    logic               s1_valid_reg;
    logic               accept;
    logic [BANK_AW-1:0] rd_addr [NUM_BANKS];
    logic [WORD_W-1:0]  rd_word [NUM_BANKS];
    logic [WORD_W-1:0]  dflt [NUM_BANKS];
    wr_t                wr [NUM_BANKS];
    res_t               res;
    res_t               head;
    logic [QCW-1:0]     q_count;
    logic [QCW-1:0]     occ;

    assign item_in = '{
        action:     action,
        cell_x:     cell_x,
        cell_y:     cell_y,
        heading:    heading,
        seen_left:  seen_left,
        seen_right: seen_right,
        seen_front: seen_front,
        wall_north: wall_north,
        wall_west:  wall_west,
        wall_south: wall_south,
        wall_east:  wall_east
    };

    assign occ      = q_count + QCW'(s1_valid_reg);
    assign in_stall = int'(occ) >= Q_DEPTH;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        rd_addr[BK_HE] = bank_addr(cell_y, 1'b0);
        rd_addr[BK_HO] = bank_addr(cell_y, 1'b1);
        rd_addr[BK_VE] = bank_addr(cell_x, 1'b0);
        rd_addr[BK_VO] = bank_addr(cell_x, 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item_in;
        end
    end

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        mwms_bank u_bank (
            .clk     (clk),
            .rst_n   (rst_n),
            .rd_en   (accept),
            .rd_addr (rd_addr[b]),
            .wr      (wr[b]),
            .dflt    (dflt[b]),
            .rd_data (rd_word[b])
        );
    end

    mwms_update u_update (
        .s1_valid (s1_valid_reg),
        .item     (s1_item_reg),
        .rd_word  (rd_word),
        .dflt     (dflt),
        .wr       (wr),
        .res      (res)
    );

    mwms_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_res  (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .count     (q_count)
    );

    assign wall_present  = head.wall_present;
    assign cell_explored = head.cell_explored;

    `MWMS_ASSERT_NOW(a_top_occ, 1'b1, int'(occ) <= Q_DEPTH,
                     "more items in flight than result slots")
    `MWMS_ASSERT_NOW(a_top_query_no_write,
                     s1_valid_reg && (s1_item_reg.action == ACT_QRY_WALL ||
                                      s1_item_reg.action == ACT_QRY_EXPL),
                     !(wr[BK_HE].en || wr[BK_HO].en || wr[BK_VE].en || wr[BK_VO].en),
                     "query item wrote the wall map")

endmodule
